[design/box_record_stream_parser_assert.svh]
// ----------------------------------------------------------------------------
// Box record stream parser assertion macros
// Shared concurrent assertion shorthands for the parser modules.
// ----------------------------------------------------------------------------
`ifndef BOX_RECORD_STREAM_PARSER_ASSERT_SVH
`define BOX_RECORD_STREAM_PARSER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define BRSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define BRSP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/brsp_pkg.sv]
// ----------------------------------------------------------------------------
// Box record stream parser package
// Payload types, status codes, queue command type and result builders.
// ----------------------------------------------------------------------------
package brsp_pkg;

  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned RecordBytes = 33;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [3:0] HdrLastOff = 4'(HeaderBytes - 1);
  localparam logic [5:0] RecLastOff = 6'(RecordBytes - 1);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgIdxMagic      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxMaxVersion = 2'd1;

  localparam logic [31:0] MagicReset      = 32'h4356_434C;
  localparam logic [31:0] MaxVersionReset = 32'd1;

  typedef enum logic [3:0] {
    StRecord  = 4'd0,
    StDone    = 4'd1,
    StSmall   = 4'd2,
    StMagic   = 4'd3,
    StVersion = 4'd4,
    StTrId    = 4'd5,
    StTrKind  = 4'd6,
    StTrMin   = 4'd7,
    StTrMax   = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhRecords = 2'd1,
    PhDrain   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] record_id;
    logic [7:0]  volume_kind;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
    logic        final_result;
  } out_word_t;

  // Command from the front end to the back end
  typedef struct packed {
    logic [7:0] data_byte;
    logic       wr_byte;     // store byte into the record hold
    logic [4:0] wr_off;
    logic       emit_rec;    // byte completes a record
    logic       has_status;
    status_e    status;
  } cmd_t;

  function automatic out_word_t status_word(input status_e st);
    out_word_t w;
    w              = '0;
    w.status       = st;
    w.final_result = 1'b1;
    return w;
  endfunction

  // Bytes of a record in file order, byte k at bits [8k+7:8k]
  function automatic out_word_t record_word(input logic [263:0] bits);
    out_word_t w;
    w.status       = StRecord;
    w.record_id    = bits[63:0];
    w.volume_kind  = bits[71:64];
    w.min_x        = bits[103:72];
    w.min_y        = bits[135:104];
    w.min_z        = bits[167:136];
    w.max_x        = bits[199:168];
    w.max_y        = bits[231:200];
    w.max_z        = bits[263:232];
    w.final_result = 1'b0;
    return w;
  endfunction

endpackage

[design/box_record_stream_parser.sv]
// ----------------------------------------------------------------------------
// Box record stream parser
// Parses a byte stream of header and box records into record and status words.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_word_i  (data_byte, end_of_file)
//   out      output     out_valid_o / out_stall_i out_word_o (status, record, final)
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while the command queue has room.
// A byte that finishes a record and also ends parsing yields two words; the
// back end loads the record word and then the status word, and the queue absorbs that gap.
// A result passes through the queue entry and then the output register before
// it is valid.
// Reset clears parse state and loads register defaults; no clearing pass.
// A stall on the output stops the back end; the front stalls only when the queue fills.
// ----------------------------------------------------------------------------
module box_record_stream_parser import brsp_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [31:0] expected_magic_q;
  logic [31:0] max_version_q;

  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;
  logic accept;
  cmd_t push_cmd;
  cmd_t head_cmd;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_magic_q <= MagicReset;
      max_version_q    <= MaxVersionReset;
    end else if (cfg_we_i) begin
      // drop writes to unknown indexes
      if (cfg_index_i == CfgIdxMagic) begin
        expected_magic_q <= cfg_data_i;
      end else if (cfg_index_i == CfgIdxMaxVersion) begin
        max_version_q <= cfg_data_i;
      end
    end
  end

  brsp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .in_word_i        (in_word_i),
    .expected_magic_i (expected_magic_q),
    .max_version_i    (max_version_q),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  brsp_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  brsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[design/brsp_front.sv]
// ----------------------------------------------------------------------------
// Box record stream parser front end
// Tracks header and record position, checks the header, issues commands.
// ----------------------------------------------------------------------------
module brsp_front import brsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_word_t    in_word_i,
  input  logic [31:0] expected_magic_i,
  input  logic [31:0] max_version_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_off_q, hdr_off_d;
  logic [5:0]  rec_off_q, rec_off_d;
  logic [23:0] asm_q, asm_d;
  logic [31:0] rec_exp_q, rec_exp_d;
  logic [31:0] rec_seen_q, rec_seen_d;
  logic        magic_ok_q, magic_ok_d;
  logic        version_ok_q, version_ok_d;

  logic [31:0] hdr_word;
  logic [31:0] seen_inc;
  logic        rearm;
  logic        eof;

  assign eof      = in_word_i.end_of_file;
  assign hdr_word = {in_word_i.data_byte, asm_q};
  assign seen_inc = rec_seen_q + 32'd1;

  always_comb begin
    phase_d      = phase_q;
    hdr_off_d    = hdr_off_q;
    rec_off_d    = rec_off_q;
    asm_d        = asm_q;
    rec_exp_d    = rec_exp_q;
    rec_seen_d   = rec_seen_q;
    magic_ok_d   = magic_ok_q;
    version_ok_d = version_ok_q;
    rearm        = 1'b0;
    push_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.data_byte  = in_word_i.data_byte;
    cmd_o.status     = StRecord;

    if (accept_i) begin
      unique case (phase_q)
        PhHeader: begin
          // shift in little endian, word completes on every fourth byte
          asm_d     = {in_word_i.data_byte, asm_q[23:8]};
          hdr_off_d = hdr_off_q + 4'd1;
          if (hdr_off_q[1:0] == 2'b11) begin
            unique case (hdr_off_q[3:2])
              2'd0:    magic_ok_d   = (hdr_word == expected_magic_i);
              2'd1:    version_ok_d = (hdr_word != 32'd0) && (hdr_word <= max_version_i);
              2'd2:    rec_exp_d    = hdr_word;
              default: ;
            endcase
          end
          if (hdr_off_q != HdrLastOff) begin
            if (eof) begin
              push_o           = 1'b1;
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StSmall;
              rearm            = 1'b1;
            end
          end else begin
            rec_seen_d = '0;
            rec_off_d  = '0;
            priority if (!magic_ok_q) begin
              push_o           = 1'b1;
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StMagic;
              phase_d          = PhDrain;
            end else if (!version_ok_q) begin
              push_o           = 1'b1;
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StVersion;
              phase_d          = PhDrain;
            end else if (rec_exp_q == 32'd0) begin
              push_o           = 1'b1;
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StDone;
              phase_d          = PhDrain;
            end else if (eof) begin
              push_o           = 1'b1;
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StTrId;
            end else begin
              phase_d = PhRecords;
            end
            rearm = eof;
          end
        end

        PhRecords: begin
          push_o       = 1'b1;
          cmd_o.wr_off = rec_off_q[4:0];
          if (rec_off_q == RecLastOff) begin
            cmd_o.emit_rec = 1'b1;
            rec_off_d      = '0;
            rec_seen_d     = seen_inc;
            if (seen_inc == rec_exp_q) begin
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StDone;
              phase_d          = PhDrain;
            end else if (eof) begin
              cmd_o.has_status = 1'b1;
              cmd_o.status     = StTrId;
            end
          end else begin
            cmd_o.wr_byte = 1'b1;
            rec_off_d     = rec_off_q + 6'd1;
            if (eof) begin
              // name the first record part still incomplete
              cmd_o.has_status = 1'b1;
              priority if (rec_off_q < 6'd7) begin
                cmd_o.status = StTrId;
              end else if (rec_off_q == 6'd7) begin
                cmd_o.status = StTrKind;
              end else if (rec_off_q < 6'd20) begin
                cmd_o.status = StTrMin;
              end else begin
                cmd_o.status = StTrMax;
              end
            end
          end
          rearm = eof;
        end

        default: begin
          rearm = eof;
        end
      endcase
    end

    if (rearm) begin
      phase_d      = PhHeader;
      hdr_off_d    = '0;
      rec_off_d    = '0;
      asm_d        = '0;
      rec_exp_d    = '0;
      rec_seen_d   = '0;
      magic_ok_d   = 1'b0;
      version_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHeader;
      hdr_off_q    <= '0;
      rec_off_q    <= '0;
      asm_q        <= '0;
      rec_exp_q    <= '0;
      rec_seen_q   <= '0;
      magic_ok_q   <= 1'b0;
      version_ok_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hdr_off_q    <= hdr_off_d;
      rec_off_q    <= rec_off_d;
      asm_q        <= asm_d;
      rec_exp_q    <= rec_exp_d;
      rec_seen_q   <= rec_seen_d;
      magic_ok_q   <= magic_ok_d;
      version_ok_q <= version_ok_d;
    end
  end

`include "box_record_stream_parser_assert.svh"

  `BRSP_ASSERT(a_rec_phase_count, clk_i, rst_ni, (phase_q == PhRecords) |-> (rec_exp_q != 32'd0), "record phase with zero record count")
  `BRSP_ASSERT(a_rec_off_range, clk_i, rst_ni, (phase_q == PhRecords) |-> (rec_off_q <= RecLastOff), "record offset out of range")

endmodule

[design/brsp_queue.sv]
// ----------------------------------------------------------------------------
// Box record stream parser command queue
// Small FIFO of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module brsp_queue import brsp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`include "box_record_stream_parser_assert.svh"

  `BRSP_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `BRSP_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o, "pop from empty queue")

endmodule

[design/brsp_back.sv]
// ----------------------------------------------------------------------------
// Box record stream parser back end
// Builds the record hold from queued bytes and drives the result register.
// ----------------------------------------------------------------------------
module brsp_back import brsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // bytes 0..31 of the record; the last byte comes straight from the command
  logic [255:0] hold_q;
  out_word_t    out_q, out_d;
  logic         out_valid_q, out_valid_d;
  logic         pend_q, pend_d;
  status_e      pend_st_q, pend_st_d;

  logic out_free;
  logic load;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    out_d     = out_q;
    pend_d    = pend_q;
    pend_st_d = pend_st_q;
    load      = 1'b0;
    q_pop_o   = 1'b0;

    if (pend_q) begin
      // second word of a command: the status after a record
      if (out_free) begin
        load   = 1'b1;
        out_d  = status_word(pend_st_q);
        pend_d = 1'b0;
      end
    end else if (q_valid_i) begin
      if (!(q_cmd_i.emit_rec || q_cmd_i.has_status) || out_free) begin
        q_pop_o = 1'b1;
        if (q_cmd_i.emit_rec) begin
          load  = 1'b1;
          out_d = record_word({q_cmd_i.data_byte, hold_q});
          if (q_cmd_i.has_status) begin
            pend_d    = 1'b1;
            pend_st_d = q_cmd_i.status;
          end
        end else if (q_cmd_i.has_status) begin
          load  = 1'b1;
          out_d = status_word(q_cmd_i.status);
        end
      end
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_cmd_i.wr_byte) begin
      hold_q[{q_cmd_i.wr_off, 3'b000} +: 8] <= q_cmd_i.data_byte;
    end
    if (load) begin
      out_q <= out_d;
    end
    pend_st_q <= pend_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

`include "box_record_stream_parser_assert.svh"

  `BRSP_ASSERT(a_pend_has_out, clk_i, rst_ni, pend_q |-> out_valid_q, "pending status without a record in the output register")
  `BRSP_ASSERT(a_record_not_final, clk_i, rst_ni, (out_valid_q && (out_q.status == StRecord)) |-> !out_q.final_result, "record word flagged final")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box record stream parser testbench
// Streams header and box-record files through the parser: directed files for
// every header check and truncation point, then a short random mix of mostly
// well-formed files. Each accepted word is predicted and each output word is
// compared field by field in order.
// ----------------------------------------------------------------------------
import brsp_pkg::*;

class box_parse_board;
  localparam int unsigned IdBytes   = 8;
  localparam int unsigned BoxMinEnd = 21;
  localparam int          MaxShown  = 10;

  logic [31:0]  magic_reg;
  logic [31:0]  max_ver_reg;
  phase_e       phase;
  logic [5:0]   offset;
  logic [31:0]  word_acc;
  logic [31:0]  rec_total;
  logic [31:0]  rec_done;
  logic         magic_good;
  logic         version_good;
  logic [263:0] rec_bits;
  out_word_t    pending_words[$];
  int           errors = 0;
  int           words_checked = 0;
  int           words_predicted = 0;
  int           bytes_taken = 0;
  int           records_out = 0;
  int           status_seen[16];

  function new();
    magic_reg   = MagicReset;
    max_ver_reg = MaxVersionReset;
    rec_bits    = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    rearm();
  endfunction

  function void rearm();
    phase        = PhHeader;
    offset       = '0;
    word_acc     = '0;
    rec_total    = '0;
    rec_done     = '0;
    magic_good   = 1'b0;
    version_good = 1'b0;
  endfunction

  function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    if (idx == CfgIdxMagic) magic_reg = val;
    else if (idx == CfgIdxMaxVersion) max_ver_reg = val;
  endfunction

  function void push_status(input status_e st);
    out_word_t w;
    w              = '0;
    w.status       = st;
    w.final_result = 1'b1;
    pending_words.insert(pending_words.size(), w);
    words_predicted++;
  endfunction

  function void push_record();
    out_word_t w;
    w.status       = StRecord;
    w.record_id    = rec_bits[63:0];
    w.volume_kind  = rec_bits[71:64];
    w.min_x        = rec_bits[103:72];
    w.min_y        = rec_bits[135:104];
    w.min_z        = rec_bits[167:136];
    w.max_x        = rec_bits[199:168];
    w.max_y        = rec_bits[231:200];
    w.max_z        = rec_bits[263:232];
    w.final_result = 1'b0;
    pending_words.insert(pending_words.size(), w);
    words_predicted++;
  endfunction

  // Advance the parse by one accepted byte and queue the words it yields.
  function void take_byte(input in_word_t w);
    logic [7:0] b;
    logic       eof;
    logic [3:0] hoff;
    b   = w.data_byte;
    eof = w.end_of_file;
    bytes_taken++;
    case (phase)
      PhHeader: begin
        hoff = offset[3:0];
        word_acc[8*hoff[1:0] +: 8] = b;
        offset = {2'b00, hoff} + 6'd1;
        if (hoff[1:0] == 2'd3) begin
          case (hoff[3:2])
            2'd0: magic_good = (word_acc == magic_reg);
            2'd1: version_good = (word_acc != '0) && (word_acc <= max_ver_reg);
            2'd2: rec_total = word_acc;
            default: ;
          endcase
          word_acc = '0;
        end
        if (offset < HeaderBytes) begin
          if (eof) push_status(StSmall);
        end else begin
          offset   = '0;
          rec_done = '0;
          if (!magic_good) begin
            push_status(StMagic);
            phase = PhDrain;
          end else if (!version_good) begin
            push_status(StVersion);
            phase = PhDrain;
          end else if (rec_total == '0) begin
            push_status(StDone);
            phase = PhDrain;
          end else if (eof) begin
            push_status(StTrId);
          end else begin
            phase = PhRecords;
          end
        end
      end
      PhRecords: begin
        if (offset == '0) rec_bits = '0;
        rec_bits[8*offset +: 8] = b;
        offset = offset + 6'd1;
        if (offset == RecordBytes) begin
          offset = '0;
          push_record();
          rec_done = rec_done + 32'd1;
          if (rec_done == rec_total) begin
            push_status(StDone);
            phase = PhDrain;
          end else if (eof) begin
            push_status(StTrId);
          end
        end else if (eof) begin
          if (offset < IdBytes) push_status(StTrId);
          else if (offset == IdBytes) push_status(StTrKind);
          else if (offset < BoxMinEnd) push_status(StTrMin);
          else push_status(StTrMax);
        end
      end
      default: ;
    endcase
    if (eof) rearm();
  endfunction

  function void report(input string why, input out_word_t want, input out_word_t got);
    errors++;
    if (errors <= MaxShown) begin
      $display("%0t: %s", $time, why);
      $display("  exp st=%0d id=%h kind=%h min=%h/%h/%h max=%h/%h/%h fin=%b",
               want.status, want.record_id, want.volume_kind, want.min_x, want.min_y,
               want.min_z, want.max_x, want.max_y, want.max_z, want.final_result);
      $display("  got st=%0d id=%h kind=%h min=%h/%h/%h max=%h/%h/%h fin=%b",
               got.status, got.record_id, got.volume_kind, got.min_x, got.min_y,
               got.min_z, got.max_x, got.max_y, got.max_z, got.final_result);
    end
  endfunction

  function void check_word(input out_word_t got);
    out_word_t want;
    logic      bad;
    if (pending_words.size() == 0) begin
      report("output word with nothing predicted", '0, got);
      return;
    end
    want = pending_words.pop_front();
    words_checked++;
    status_seen[want.status]++;
    if (want.status == StRecord) records_out++;
    bad = (got.status !== want.status) || (got.record_id !== want.record_id) ||
          (got.volume_kind !== want.volume_kind) || (got.min_x !== want.min_x) ||
          (got.min_y !== want.min_y) || (got.min_z !== want.min_z) ||
          (got.max_x !== want.max_x) || (got.max_y !== want.max_y) ||
          (got.max_z !== want.max_z) || (got.final_result !== want.final_result);
    if (bad) report("output word mismatch", want, got);
  endfunction
endclass

module testbench;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 2'd3;
  localparam int TotalBytes   = 750;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 100;
  localparam int TimeLimitNs  = 10_000_000;

  typedef enum logic [1:0] {FillRandom, FillZero, FillOnes} fill_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  box_parse_board sb = new();

  logic [7:0] file_bytes[$];
  logic       calm = 1'b0;
  logic       hold_req = 1'b0;
  int         bytes_sent = 0;
  int         files_sent = 0;
  int         stall_cycles = 0;

  box_record_stream_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_byte(in_word_i);
      if (in_valid_i && in_stall_o) stall_cycles++;
      if (out_valid_o && !out_stall_i) sb.check_word(out_word_o);
    end
  end

  // Mostly no gap, some short ones, a few long ones; none while calm.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin : receiver
    int n;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
      end
    end
  end

  function automatic void push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) file_bytes.insert(file_bytes.size(), w[8*k +: 8]);
  endfunction

  function automatic void push_header(input logic [31:0] m, input logic [31:0] v,
                                      input logic [31:0] n);
    push_word(m);
    push_word(v);
    push_word(n);
    push_word($urandom());
  endfunction

  function automatic void push_record(input fill_e fill);
    for (int k = 0; k < RecordBytes; k++) begin
      case (fill)
        FillZero: file_bytes.insert(file_bytes.size(), 8'h00);
        FillOnes: file_bytes.insert(file_bytes.size(), 8'hFF);
        default:  file_bytes.insert(file_bytes.size(), 8'($urandom()));
      endcase
    end
  endfunction

  function automatic void push_noise(input int n);
    repeat (n) file_bytes.insert(file_bytes.size(), 8'($urandom()));
  endfunction

  function automatic void cut_file(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endfunction

  // Hold valid high through back-to-back words; drop it only for a gap.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{data_byte: b, end_of_file: eof};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
    files_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic new_settings();
    logic [31:0] m;
    logic [31:0] v;
    settle();
    case ($urandom_range(3, 0))
      0:       m = MagicReset;
      1:       m = '0;
      2:       m = '1;
      default: m = $urandom();
    endcase
    case ($urandom_range(3, 0))
      0:       v = MaxVersionReset;
      1:       v = '1;
      default: v = $urandom_range(8, 1);
    endcase
    write_reg(CfgIdxMagic, m);
    write_reg(CfgIdxMaxVersion, v);
    if ($urandom_range(1, 0)) begin
      write_reg($urandom_range(1, 0) ? CfgIdxSpareA : CfgIdxSpareB, $urandom());
    end
  endtask

  task automatic random_file();
    int          kind;
    int          cnt;
    logic [31:0] ver;
    logic [31:0] hdr_cnt;
    logic [31:0] bad_ver;
    kind    = $urandom_range(99, 0);
    cnt     = $urandom_range(3, 1);
    ver     = $urandom_range(sb.max_ver_reg, 1);
    hdr_cnt = cnt;
    if (kind < 80) begin
      if (kind >= 72) hdr_cnt = $urandom() | 32'd4;
      push_header(sb.magic_reg, ver, hdr_cnt);
      repeat (cnt) push_record(FillRandom);
      if (kind < 65) begin
        if ($urandom_range(3, 0) == 0) push_noise($urandom_range(6, 1));
      end else begin
        cut_file($urandom_range(file_bytes.size() - 1, 1));
      end
    end else if (kind < 88) begin
      push_header(sb.magic_reg ^ (32'd1 << $urandom_range(31, 0)), ver, hdr_cnt);
      push_noise($urandom_range(8, 0));
    end else if (kind < 94) begin
      bad_ver = (sb.max_ver_reg == '1 || $urandom_range(1, 0)) ? '0 : sb.max_ver_reg + 1;
      push_header(sb.magic_reg, bad_ver, hdr_cnt);
      push_noise($urandom_range(8, 0));
    end else begin
      push_noise($urandom_range(40, 1));
    end
    send_file();
  endtask

  initial begin : stimulus
    int cuts[7] = '{1, 7, 8, 9, 20, 21, 32};
    bit hold_used;
    hold_used = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short files
    push_noise(1);
    send_file();
    push_header(sb.magic_reg, 1, 1);
    cut_file(HeaderBytes - 1);
    send_file();
    // header checks; magic takes priority over version
    push_header(~sb.magic_reg, 0, 1);
    send_file();
    push_header(sb.magic_reg, 0, 1);
    push_noise(3);
    send_file();
    push_header(sb.magic_reg, sb.max_ver_reg + 1, 1);
    send_file();
    push_header(sb.magic_reg, sb.max_ver_reg, 0);
    push_noise(2);
    send_file();
    push_header(sb.magic_reg, 1, 2);
    send_file();
    // end of file inside each part of a record
    foreach (cuts[i]) begin
      push_header(sb.magic_reg, 1, 1);
      push_record(FillRandom);
      cut_file(HeaderBytes + cuts[i]);
      send_file();
    end
    push_header(sb.magic_reg, 1, 2);
    push_record(FillZero);
    send_file();
    push_header(sb.magic_reg, 1, 1);
    push_record(FillOnes);
    send_file();
    push_header(sb.magic_reg, 1, 1);
    push_record(FillRandom);
    push_noise(4);
    send_file();
    push_header(sb.magic_reg, 1, '1);
    push_record(FillRandom);
    push_record(FillRandom);
    send_file();

    // register extremes, plus writes to unused indexes
    settle();
    write_reg(CfgIdxMagic, '0);
    write_reg(CfgIdxMaxVersion, '1);
    write_reg(CfgIdxSpareA, '1);
    write_reg(CfgIdxSpareB, '0);
    push_header('0, '1, 1);
    push_record(FillRandom);
    send_file();
    settle();
    write_reg(CfgIdxMagic, '1);
    write_reg(CfgIdxMaxVersion, 1);
    push_header('1, 2, 1);
    send_file();
    push_header('1, 1, 1);
    push_record(FillRandom);
    send_file();
    settle();
    write_reg(CfgIdxMagic, MagicReset);
    write_reg(CfgIdxMaxVersion, MaxVersionReset);

    while (bytes_sent < TotalBytes) begin
      if (files_sent % 8 == 0) new_settings();
      calm = ($urandom_range(4, 0) == 0);
      if (!hold_used) begin
        // stall the output long enough for the queue to back up into the input
        hold_used = 1'b1;
        hold_req  = 1'b1;
        calm      = 1'b1;
        push_header(sb.magic_reg, 1, 1);
        push_record(FillRandom);
        send_file();
      end else begin
        random_file();
      end
    end
    calm = 1'b0;

    settle();
    $display("Covered %0d files, %0d bytes, %0d result words (%0d records)",
             files_sent, sb.bytes_taken, sb.words_checked, sb.records_out);
    $display("Input stalled %0d cycles; status words: done %0d, short %0d, magic %0d,",
             stall_cycles, sb.status_seen[StDone], sb.status_seen[StSmall],
             sb.status_seen[StMagic]);
    $display("  version %0d, cut id/kind/min/max %0d/%0d/%0d/%0d",
             sb.status_seen[StVersion], sb.status_seen[StTrId], sb.status_seen[StTrKind],
             sb.status_seen[StTrMin], sb.status_seen[StTrMax]);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("box_record_stream_parser verification clean");
    end else begin
      $display("%0d mismatches, %0d words never arrived", sb.errors, sb.pending_words.size());
      $display("box_record_stream_parser verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeLimitNs);
    $display("Timed out with %0d words outstanding", sb.pending_words.size());
    $display("box_record_stream_parser verification failed");
    $finish;
  end

endmodule
